// ----- sv/dphs_pkg.sv -----
// ----------------------------------------------------------------------------
// dphs_pkg
// Shared widths, register codes and result codes of the hand-side classifier.
// ----------------------------------------------------------------------------
package dphs_pkg;

   localparam int COORD_BITS_DEF = 12;

   // Input fields
   localparam int COL_W   = 12;
   localparam int LABEL_W = 8;
   localparam int Z_W     = 16;

   // Configuration fields
   localparam int CTR_W = 20;
   localparam int INV_W = 24;
   localparam int WR_W  = 21;
   localparam int RAD_W = 16;
   localparam int R2_W  = 2 * RAD_W;

   // Result and arithmetic widths
   localparam int PT_W      = 19;
   localparam int FRAC_BITS = 40;
   localparam int SQ_W      = 2 * WR_W;
   localparam int DIST_W    = SQ_W + 2;

   // Port widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 63;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WRIST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WRIST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 3'd6;

   localparam logic [CTR_W-1:0] CENTER_X_RST    = 20'd81920;
   localparam logic [CTR_W-1:0] CENTER_Y_RST    = 20'd61440;
   localparam logic [INV_W-1:0] INV_FOCAL_RST   = 24'd8180999;

   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_LEFT  = 2'd1,
      SIDE_RIGHT = 2'd2
   } side_type;

endpackage

// ----- sv/dphs_backproj.sv -----
// ----------------------------------------------------------------------------
// dphs_backproj
// One back-projection lane: offset from principal point, two multiplies,
// round half away from zero and saturate. Four register stages.
// ----------------------------------------------------------------------------
module dphs_backproj import dphs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [COL_W-1:0]       pix,
   input  logic [CTR_W-1:0]       ctr,
   input  logic [INV_W-1:0]       inv,
   input  logic [Z_W-1:0]         depth,
   output logic signed [PT_W-1:0] coord
);

   localparam int PIX_W = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
   localparam int MAG_W = (COORD_BITS + 8 > CTR_W) ? COORD_BITS + 8 : CTR_W;
   localparam int P1_W  = MAG_W + INV_W;
   localparam int P2_W  = P1_W + Z_W;
   localparam int RND_W = P2_W + 1 - FRAC_BITS;
   localparam logic [RND_W-1:0] NEG_LIM = RND_W'(2 ** (PT_W - 1));
   localparam logic [RND_W-1:0] POS_LIM = RND_W'(2 ** (PT_W - 1) - 1);
   localparam logic [P2_W:0]    HALF    = (P2_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [PT_W-1:0]  PT_MIN  = {1'b1, {(PT_W - 1){1'b0}}};
   localparam logic [PT_W-1:0]  PT_MAX  = {1'b0, {(PT_W - 1){1'b1}}};

   logic [MAG_W:0]   diff;
   logic [MAG_W:0]   neg_diff;
   logic [MAG_W-1:0] mag_in, mag_ff;
   logic             neg1_in, neg1_ff, neg2_ff, neg3_ff;
   logic [Z_W-1:0]   dep1_ff, dep2_ff;
   logic [P1_W-1:0]  p1_in, p1_ff;
   logic [P2_W-1:0]  p2_in, p2_ff;
   logic [P2_W:0]    rsum;
   logic [RND_W-1:0] rnd, rnd_neg;
   logic [PT_W-1:0]  coord_in, coord_ff;

   always_comb begin
      diff     = {1'b0, MAG_W'({pix[PIX_W-1:0], 8'h00})} - {1'b0, MAG_W'(ctr)};
      neg_diff = -diff;
      neg1_in  = diff[MAG_W];
      mag_in   = neg1_in ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
      p1_in    = P1_W'(mag_ff) * P1_W'(inv);
      p2_in    = P2_W'(p1_ff) * P2_W'(dep2_ff);
      rsum     = {1'b0, p2_ff} + HALF;
      rnd      = rsum[P2_W:FRAC_BITS];
      rnd_neg  = -rnd;
      if (neg3_ff) begin
         coord_in = (rnd > NEG_LIM) ? PT_MIN : rnd_neg[PT_W-1:0];
      end else begin
         coord_in = (rnd > POS_LIM) ? PT_MAX : rnd[PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         neg1_ff  <= neg1_in;
         dep1_ff  <= depth;
         p1_ff    <= p1_in;
         neg2_ff  <= neg1_ff;
         dep2_ff  <= dep1_ff;
         p2_ff    <= p2_in;
         neg3_ff  <= neg2_ff;
         coord_ff <= coord_in;
      end
   end

   assign coord = signed'(coord_ff);

endmodule

// ----- sv/dphs_sqdist.sv -----
// ----------------------------------------------------------------------------
// dphs_sqdist
// Squared distance from a point to one wrist: absolute differences, squares,
// sum. Three register stages.
// ----------------------------------------------------------------------------
module dphs_sqdist import dphs_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [PT_W-1:0] x,
   input  logic signed [PT_W-1:0] y,
   input  logic [Z_W-1:0]         z,
   input  logic [3*WR_W-1:0]      wrist,
   output logic [DIST_W-1:0]      dist_sq
);

   localparam int DW = WR_W + 1;

   logic signed [DW-1:0] dx, dy, dz;
   logic [DW-1:0]        nx, ny, nz;
   logic [WR_W-1:0]      ax_in, ay_in, az_in, ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]      sx_in, sy_in, sz_in, sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0]    dist_in, dist_ff;

   always_comb begin
      dx = DW'(x) - DW'(signed'(wrist[WR_W-1:0]));
      dy = DW'(y) - DW'(signed'(wrist[2*WR_W-1:WR_W]));
      dz = DW'(signed'({1'b0, z})) - DW'(signed'(wrist[3*WR_W-1:2*WR_W]));
      nx = -dx;
      ny = -dy;
      nz = -dz;
      ax_in = dx[DW-1] ? nx[WR_W-1:0] : dx[WR_W-1:0];
      ay_in = dy[DW-1] ? ny[WR_W-1:0] : dy[WR_W-1:0];
      az_in = dz[DW-1] ? nz[WR_W-1:0] : dz[WR_W-1:0];
      sx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);
      sz_in = SQ_W'(az_ff) * SQ_W'(az_ff);
      dist_in = DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         az_ff   <= az_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sz_ff   <= sz_in;
         dist_ff <= dist_in;
      end
   end

   assign dist_sq = dist_ff;

endmodule

// ----- sv/depth_pixel_hand_side_classifier.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_hand_side_classifier
// Back-projects hand pixels to 3-D millimeter points and tags the nearer hand.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock unless the output stalls, and presents one
// point beat for every pixel with a nonzero mask byte and nonzero depth after
// four stages of back-projection (offset, offset times reciprocal focal
// length, times depth, round and saturate), three stages of squared wrist
// distance (absolute difference, square, sum) and the output register that
// holds the side decision. Other pixels are dropped. The whole pipeline holds
// while a result waits on rsp_tready, so req_tready follows it. Registers
// must be written only while no pixel is in flight; the block itself does
// not enforce this.
module depth_pixel_hand_side_classifier import dphs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pixel_col[11:0], pixel_row[23:12], hand_label[31:24], depth_mm[47:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // point_x_mm[18:0], point_y_mm[37:19], point_z_mm[53:38], hand_side[55:54]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NST = 7;

   logic [COL_W-1:0]     pixel_col, pixel_row;
   logic [LABEL_W-1:0]   hand_label;
   logic [Z_W-1:0]       depth_mm;
   logic                 en, accept;

   logic [CTR_W-1:0]     center_x_ff, center_y_ff;
   logic [INV_W-1:0]     inv_fx_ff, inv_fy_ff;
   logic [3*WR_W-1:0]    left_ff, right_ff;
   logic [RAD_W-1:0]     radius_ff;
   logic [R2_W-1:0]      r2_in, r2_ff;

   logic [NST:1]         vld_in, vld_ff;
   logic [Z_W-1:0]       z_ff [1:NST];
   logic [PT_W-1:0]      xd_ff [5:NST];
   logic [PT_W-1:0]      yd_ff [5:NST];
   logic signed [PT_W-1:0] x4, y4;
   logic [DIST_W-1:0]    dl, dr;
   logic                 near_l, near_r;
   side_type             side_in, side_ff;
   logic [PT_W-1:0]      px_ff, py_ff;
   logic [Z_W-1:0]       pz_ff;
   logic                 rsp_valid_in, rsp_valid_ff;

   assign pixel_col  = req_tdata[COL_W-1:0];
   assign pixel_row  = req_tdata[2*COL_W-1:COL_W];
   assign hand_label = req_tdata[2*COL_W+LABEL_W-1:2*COL_W];
   assign depth_mm   = req_tdata[REQ_DATA_W-1:2*COL_W+LABEL_W];

   // Advance everything when the output register is free or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // ---------------------------------------------------------------- CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_X_RST;
         center_y_ff <= CENTER_Y_RST;
         inv_fx_ff   <= INV_FOCAL_RST;
         inv_fy_ff   <= INV_FOCAL_RST;
         left_ff     <= '0;
         right_ff    <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_ff <= csr_wdata[CTR_W-1:0];
            CSR_CENTER_Y:    center_y_ff <= csr_wdata[CTR_W-1:0];
            CSR_INV_FOCAL_X: inv_fx_ff   <= csr_wdata[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_fy_ff   <= csr_wdata[INV_W-1:0];
            CSR_LEFT_WRIST:  left_ff     <= csr_wdata[3*WR_W-1:0];
            CSR_RIGHT_WRIST: right_ff    <= csr_wdata[3*WR_W-1:0];
            CSR_RADIUS:      radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign r2_in = R2_W'(radius_ff) * R2_W'(radius_ff);

   always_ff @(posedge clock) begin
      r2_ff <= r2_in;
   end

   // ---------------------------------------------------------- datapath
   dphs_backproj #(.COORD_BITS(COORD_BITS)) u_bp_x (
      .clock (clock),
      .en    (en),
      .pix   (pixel_col),
      .ctr   (center_x_ff),
      .inv   (inv_fx_ff),
      .depth (depth_mm),
      .coord (x4)
   );

   dphs_backproj #(.COORD_BITS(COORD_BITS)) u_bp_y (
      .clock (clock),
      .en    (en),
      .pix   (pixel_row),
      .ctr   (center_y_ff),
      .inv   (inv_fy_ff),
      .depth (depth_mm),
      .coord (y4)
   );

   dphs_sqdist u_dist_l (
      .clock   (clock),
      .en      (en),
      .x       (x4),
      .y       (y4),
      .z       (z_ff[4]),
      .wrist   (left_ff),
      .dist_sq (dl)
   );

   dphs_sqdist u_dist_r (
      .clock   (clock),
      .en      (en),
      .x       (x4),
      .y       (y4),
      .z       (z_ff[4]),
      .wrist   (right_ff),
      .dist_sq (dr)
   );

   // Drop masked and empty pixels at the door.
   always_comb begin
      vld_in         = {vld_ff[NST-1:1], 1'b0};
      vld_in[1]      = accept && (hand_label != '0) && (depth_mm != '0);
      near_l         = dl < DIST_W'(r2_ff);
      near_r         = dr < DIST_W'(r2_ff);
      if (near_l && near_r) begin
         side_in = (dl < dr) ? SIDE_LEFT : SIDE_RIGHT;
      end else if (near_l) begin
         side_in = SIDE_LEFT;
      end else if (near_r) begin
         side_in = SIDE_RIGHT;
      end else begin
         side_in = SIDE_NONE;
      end
      rsp_valid_in   = vld_ff[NST];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[1] <= depth_mm;
         for (int i = 2; i <= NST; i++) begin
            z_ff[i] <= z_ff[i-1];
         end
         xd_ff[5] <= x4;
         yd_ff[5] <= y4;
         for (int i = 6; i <= NST; i++) begin
            xd_ff[i] <= xd_ff[i-1];
            yd_ff[i] <= yd_ff[i-1];
         end
         px_ff   <= xd_ff[NST];
         py_ff   <= yd_ff[NST];
         pz_ff   <= z_ff[NST];
         side_ff <= side_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {side_ff, pz_ff, py_ff, px_ff};

`ifndef SYNTH
   a_side_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (side_ff == SIDE_NONE || side_ff == SIDE_LEFT ||
                      side_ff == SIDE_RIGHT))
      else $error("hand side code out of range");

   a_no_empty_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pz_ff != '0))
      else $error("result beat with zero depth");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[NST] && r2_ff == '0) |=> (side_ff == SIDE_NONE))
      else $error("zero radius gave a hand side");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (en && !vld_ff[NST]) |=> !rsp_tvalid)
      else $error("result beat without a pixel behind it");
`endif

endmodule

// ----- tb/sv/tb_depth_pixel_hand_side_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_depth_pixel_hand_side_classifier
// Self-checking bench for the hand-pixel back-projection and side classifier.
// ----------------------------------------------------------------------------
// Pixels are sent on the req stream and every pixel with a hand mask and a
// depth reading is projected here in fixed point, then classified against
// both wrists. The projected points wait in order until the rsp stream
// delivers them. Each arriving point is compared field by field. The bench
// runs directed cases first: masked pixels, saturation, rounding, register
// masking and every side decision. It then runs randomized rounds with
// wrists placed near the sampled points, fully random rounds and a long
// receiver hold-off. Both stream sides idle at random.
module tb_depth_pixel_hand_side_classifier;
   import dphs_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << COORD_BITS_DEF) - 1);
   localparam logic signed [PT_W-1:0] PT_MAX = PT_W'(2 ** (PT_W - 1) - 1);
   localparam logic signed [PT_W-1:0] PT_MIN = PT_W'(-(2 ** (PT_W - 1)));

   typedef struct packed {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
      logic [Z_W-1:0]         z;
      side_type               side;
   } point_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // register copies
   logic [CTR_W-1:0]      cfg_center_x = CENTER_X_RST;
   logic [CTR_W-1:0]      cfg_center_y = CENTER_Y_RST;
   logic [INV_W-1:0]      cfg_inv_x    = INV_FOCAL_RST;
   logic [INV_W-1:0]      cfg_inv_y    = INV_FOCAL_RST;
   logic [3*WR_W-1:0]     cfg_left     = '0;
   logic [3*WR_W-1:0]     cfg_right    = '0;
   logic [RAD_W-1:0]      cfg_radius   = '0;

   point_type pending_points[$];
   int     error_count   = 0;
   int     stall_cycles  = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_left     = 0;
   bit     hold_request  = 0;

   depth_pixel_hand_side_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---- prediction ---------------------------------------------------------

   function automatic logic signed [PT_W-1:0] project_axis(input logic [COL_W-1:0] pix,
         input logic [CTR_W-1:0] ctr, input logic [INV_W-1:0] inv,
         input logic [Z_W-1:0] depth);
      longint      offset;
      logic [63:0] mag;
      logic        neg;
      offset = longint'({pix & COL_MASK, 8'd0}) - longint'(ctr);
      neg = offset < 0;
      mag = neg ? -offset : offset;
      mag = mag * inv * depth;
      mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (neg) begin
         if (mag > 64'(2 ** (PT_W - 1))) return PT_MIN;
         return -mag[PT_W-1:0];
      end
      if (mag > 64'(PT_MAX)) return PT_MAX;
      return mag[PT_W-1:0];
   endfunction

   function automatic logic [63:0] wrist_dist_sq(input longint x, input longint y,
         input longint z, input logic [3*WR_W-1:0] wrist);
      longint dx, dy, dz;
      dx = x - longint'($signed(wrist[WR_W-1:0]));
      dy = y - longint'($signed(wrist[2*WR_W-1:WR_W]));
      dz = z - longint'($signed(wrist[3*WR_W-1:2*WR_W]));
      return dx * dx + dy * dy + dz * dz;
   endfunction

   // Queue the point a pixel produces; masked or empty pixels produce none.
   function automatic void project_pixel(input logic [COL_W-1:0] col,
         input logic [COL_W-1:0] row, input logic [LABEL_W-1:0] label,
         input logic [Z_W-1:0] depth);
      point_type   pt;
      logic [63:0] r2, dl, dr;
      logic        near_l, near_r;
      if (label == '0 || depth == '0) return;
      pt.x = project_axis(col, cfg_center_x, cfg_inv_x, depth);
      pt.y = project_axis(row, cfg_center_y, cfg_inv_y, depth);
      pt.z = depth;
      r2 = 64'(cfg_radius) * 64'(cfg_radius);
      dl = wrist_dist_sq(pt.x, pt.y, depth, cfg_left);
      dr = wrist_dist_sq(pt.x, pt.y, depth, cfg_right);
      near_l = dl < r2;
      near_r = dr < r2;
      if (near_l && near_r) pt.side = (dl < dr) ? SIDE_LEFT : SIDE_RIGHT;
      else if (near_l) pt.side = SIDE_LEFT;
      else if (near_r) pt.side = SIDE_RIGHT;
      else pt.side = SIDE_NONE;
      pending_points = {pending_points, pt};
   endfunction

   // ---- stimulus helpers ---------------------------------------------------

   function automatic int jitter(input int center, input int span, input int lo,
         input int hi);
      int v;
      v = center + int'($urandom_range(2 * span)) - span;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [3*WR_W-1:0] pack_wrist(input int x, input int y, input int z);
      return {WR_W'(z), WR_W'(y), WR_W'(x)};
   endfunction

   // Wrist within 40 millimeters per axis of where this pixel lands.
   function automatic logic [3*WR_W-1:0] wrist_near(input int col, input int row,
         input int depth);
      int x, y;
      x = project_axis(COL_W'(col), cfg_center_x, cfg_inv_x, Z_W'(depth));
      y = project_axis(COL_W'(row), cfg_center_y, cfg_inv_y, Z_W'(depth));
      return pack_wrist(jitter(x, 40, -1000000, 1000000), jitter(y, 40, -1000000, 1000000),
                        jitter(depth, 40, -1000000, 1000000));
   endfunction

   task automatic set_idling(input int phase);
      case (phase)
         0: begin
            send_idle_pct = 30;
            recv_idle_pct = 88;
         end
         1: begin
            send_idle_pct = 88;
            recv_idle_pct = 30;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CENTER_X:    cfg_center_x = value[CTR_W-1:0];
         CSR_CENTER_Y:    cfg_center_y = value[CTR_W-1:0];
         CSR_INV_FOCAL_X: cfg_inv_x    = value[INV_W-1:0];
         CSR_INV_FOCAL_Y: cfg_inv_y    = value[INV_W-1:0];
         CSR_LEFT_WRIST:  cfg_left     = value[3*WR_W-1:0];
         CSR_RIGHT_WRIST: cfg_right    = value[3*WR_W-1:0];
         CSR_RADIUS:      cfg_radius   = value[RAD_W-1:0];
         default: ;
      endcase
   endtask

   // Hold valid across back-to-back beats; lower it only for a gap.
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
         input logic [LABEL_W-1:0] label, input logic [Z_W-1:0] depth);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {depth, label, row, col};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         if (taken) project_pixel(col, row, label, depth);
         @(posedge clock);
      end
   endtask

   // Wait out every pending point, then let dropped pixels clear the pipe.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic restore_intrinsics;
      write_reg(CSR_CENTER_X, 63'(CENTER_X_RST));
      write_reg(CSR_CENTER_Y, 63'(CENTER_Y_RST));
      write_reg(CSR_INV_FOCAL_X, 63'(INV_FOCAL_RST));
      write_reg(CSR_INV_FOCAL_Y, 63'(INV_FOCAL_RST));
   endtask

   // ---- tests --------------------------------------------------------------

   task automatic test_reset_defaults;
      send_pixel(12'd320, 12'd240, 8'd1, 16'd1000);
      send_pixel(12'd0, 12'd0, 8'd255, 16'hFFFF);
      send_pixel(12'd100, 12'd50, 8'd0, 16'd500);
      send_pixel(12'd100, 12'd50, 8'd7, 16'd0);
      send_pixel(12'd100, 12'd50, 8'd0, 16'd0);
      send_pixel(12'hFFF, 12'hFFF, 8'd128, 16'd1);
      drain();
   endtask

   task automatic test_projection_extremes;
      write_reg(CSR_CENTER_X, 63'd0);
      write_reg(CSR_CENTER_Y, 63'd0);
      write_reg(CSR_INV_FOCAL_X, 63'hFF_FFFF);
      write_reg(CSR_INV_FOCAL_Y, 63'hFF_FFFF);
      send_pixel(12'hFFF, 12'hFFF, 8'd255, 16'hFFFF);
      drain();
      write_reg(CSR_CENTER_X, 63'hF_FFFF);
      write_reg(CSR_CENTER_Y, 63'hF_FFFF);
      send_pixel(12'd0, 12'd0, 8'd1, 16'hFFFF);
      send_pixel(12'hFFF, 12'd0, 8'd1, 16'd1);
      drain();
      write_reg(CSR_INV_FOCAL_X, 63'd0);
      send_pixel(12'd5, 12'd9, 8'd3, 16'hFFFF);
      drain();
      // exact half-millimeter products round away from zero, one depth unit less rounds to zero
      write_reg(CSR_CENTER_X, 63'd0);
      write_reg(CSR_CENTER_Y, 63'd2);
      write_reg(CSR_INV_FOCAL_X, 63'd65536);
      write_reg(CSR_INV_FOCAL_Y, 63'd8388608);
      send_pixel(12'd1, 12'd0, 8'd1, 16'd32768);
      send_pixel(12'd1, 12'd0, 8'd1, 16'd32767);
      drain();
   endtask

   task automatic test_register_masking;
      write_reg(CSR_CENTER_X, 63'h7FFF_FFFF_FFF1_4000);
      write_reg(CSR_INV_FOCAL_Y, 63'h7FFF_FFFF_FF7C_D507);
      write_reg(CSR_RADIUS, 63'h7FFF_FFFF_FFFF_0000);
      write_reg(CSR_SPARE, '1);
      send_pixel(12'd400, 12'd300, 8'd9, 16'd1200);
      send_pixel(12'd17, 12'd460, 8'd1, 16'd2500);
      drain();
   endtask

   task automatic side_case(input int lx, input int ly, input int lz, input int rx,
         input int ry, input int rz);
      int px, py;
      px = project_axis(12'd300, cfg_center_x, cfg_inv_x, 16'd800);
      py = project_axis(12'd200, cfg_center_y, cfg_inv_y, 16'd800);
      write_reg(CSR_LEFT_WRIST, 63'(pack_wrist(px + lx, py + ly, 800 + lz)));
      write_reg(CSR_RIGHT_WRIST, 63'(pack_wrist(px + rx, py + ry, 800 + rz)));
      send_pixel(12'd300, 12'd200, 8'd1, 16'd800);
      drain();
   endtask

   task automatic test_side_selection;
      restore_intrinsics();
      write_reg(CSR_RADIUS, 63'd100);
      side_case(10, 0, 0, 500, 0, 0);
      side_case(500, 0, 0, 0, 10, 0);
      side_case(30, 0, 0, 0, 0, 30);
      side_case(5, -5, 5, 5, -5, 5);
      side_case(10, 0, 0, 0, 40, 0);
      side_case(0, 0, -50, 20, 0, 0);
      // squared distance equal to the squared radius is outside
      side_case(100, 0, 0, 0, -300, 0);
      side_case(0, 700, 0, -900, 0, 0);
      write_reg(CSR_RADIUS, 63'd0);
      side_case(0, 0, 0, 0, 0, 0);
   endtask

   // Wrists sit near two anchor pixels; most beats sample around them.
   task automatic test_random_hands(input int rounds, input int beats);
      int lc, lr, ld, rc, rr, rd, pick;
      bit use_left;
      for (int r = 0; r < rounds; r++) begin
         write_reg(CSR_CENTER_X, 63'(CENTER_X_RST - 2048 + $urandom_range(4096)));
         write_reg(CSR_CENTER_Y, 63'(CENTER_Y_RST - 2048 + $urandom_range(4096)));
         write_reg(CSR_INV_FOCAL_X, 63'(INV_FOCAL_RST - 500000 + $urandom_range(1000000)));
         write_reg(CSR_INV_FOCAL_Y, 63'(INV_FOCAL_RST - 500000 + $urandom_range(1000000)));
         lc = $urandom_range(600, 40);
         lr = $urandom_range(440, 40);
         ld = $urandom_range(2500, 400);
         if ($urandom_range(2) == 0) begin
            rc = jitter(lc, 30, 0, 4095);
            rr = jitter(lr, 30, 0, 4095);
            rd = jitter(ld, 60, 1, 65535);
         end else begin
            rc = $urandom_range(600, 40);
            rr = $urandom_range(440, 40);
            rd = $urandom_range(2500, 400);
         end
         write_reg(CSR_LEFT_WRIST, 63'(wrist_near(lc, lr, ld)));
         write_reg(CSR_RIGHT_WRIST, 63'(wrist_near(rc, rr, rd)));
         write_reg(CSR_RADIUS, (r == rounds - 1) ? 63'hFFFF : 63'($urandom_range(400, 40)));
         for (int i = 0; i < beats; i++) begin
            set_idling(i * 3 / beats);
            pick = $urandom_range(99);
            use_left = 1'($urandom_range(1));
            if (pick < 80)
               send_pixel(COL_W'(jitter(use_left ? lc : rc, 60, 0, 4095)),
                          COL_W'(jitter(use_left ? lr : rr, 60, 0, 4095)),
                          LABEL_W'($urandom_range(255, 1)),
                          Z_W'(jitter(use_left ? ld : rd, 150, 1, 65535)));
            else if (pick < 90)
               send_pixel(COL_W'(jitter(lc, 60, 0, 4095)), COL_W'(jitter(lr, 60, 0, 4095)),
                          (pick < 85) ? 8'd0 : 8'($urandom_range(255, 1)),
                          (pick < 85) ? 16'($urandom) : 16'd0);
            else
               send_pixel(COL_W'($urandom), COL_W'($urandom), LABEL_W'($urandom),
                          Z_W'($urandom));
         end
         drain();
      end
   endtask

   task automatic test_random_fields(input int rounds, input int beats);
      for (int r = 0; r < rounds; r++) begin
         write_reg(CSR_CENTER_X, 63'($urandom));
         write_reg(CSR_CENTER_Y, 63'($urandom));
         write_reg(CSR_INV_FOCAL_X, 63'($urandom));
         write_reg(CSR_INV_FOCAL_Y, 63'($urandom));
         write_reg(CSR_LEFT_WRIST, 63'({$urandom, $urandom}));
         write_reg(CSR_RIGHT_WRIST, 63'({$urandom, $urandom}));
         write_reg(CSR_RADIUS, (r == 0) ? 63'hFFFF : 63'($urandom));
         for (int i = 0; i < beats; i++) begin
            set_idling(i * 3 / beats);
            send_pixel(COL_W'($urandom), COL_W'($urandom),
                       ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
                       ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
         end
         drain();
      end
   endtask

   // Receiver stalls for a long stretch while pixels keep coming.
   task automatic test_backpressure(input int beats);
      restore_intrinsics();
      write_reg(CSR_LEFT_WRIST, 63'(wrist_near(320, 240, 900)));
      write_reg(CSR_RIGHT_WRIST, 63'(wrist_near(360, 240, 900)));
      write_reg(CSR_RADIUS, 63'd120);
      set_idling(2);
      hold_request = 1'b1;
      for (int i = 0; i < beats; i++)
         send_pixel(COL_W'(jitter(340, 50, 0, 4095)), COL_W'(jitter(240, 50, 0, 4095)),
                    LABEL_W'($urandom_range(255, 1)), Z_W'(jitter(900, 100, 1, 65535)));
      drain();
   endtask

   // ---- result side --------------------------------------------------------

   task automatic note_mismatch(input string what, input point_type want,
         input point_type got);
      error_count++;
      if (error_count <= 10)
         $display("%s: expected x=%0d y=%0d z=%0d side=%s, got x=%0d y=%0d z=%0d side=%s",
                  what, want.x, want.y, want.z, want.side.name(),
                  got.x, got.y, got.z, got.side.name());
   endtask

   always begin : rsp_side
      point_type got, want;
      @(negedge clock);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x    = rsp_tdata[PT_W-1:0];
         got.y    = rsp_tdata[2*PT_W-1:PT_W];
         got.z    = rsp_tdata[2*PT_W+Z_W-1:2*PT_W];
         got.side = side_type'(rsp_tdata[2*PT_W+Z_W+1:2*PT_W+Z_W]);
         if (pending_points.size() == 0) begin
            note_mismatch("unexpected point beat", got, got);
         end else begin
            want = pending_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.side !== want.side)
               note_mismatch("point mismatch", want, got);
         end
      end
      @(posedge clock);
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles += 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      set_idling(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_projection_extremes();
      test_register_masking();
      test_side_selection();
      test_random_hands(6, 160);
      test_random_fields(2, 100);
      test_backpressure(80);
      drain();
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
